// ===== sv/assert_macros.svh =====
// assertion helpers for the rtl files, used by spq_ctrl
// both expect a clock named clk and an active-low reset named rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define SPQ_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked in the cycle after a trigger
`define SPQ_ASSERT_NEXT(name, trig, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
        else $error(msg);

`endif

// ===== sv/spq_pkg.sv =====
`default_nettype none
package spq_pkg;

    // default queue capacity
    localparam int QUEUE_DEPTH_DEF = 16;

    // field widths
    localparam int TAG_W    = 32;
    localparam int PRIO_W   = 32;
    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;

    // request commands
    localparam logic CMD_INSERT  = 1'b0;
    localparam logic CMD_EXTRACT = 1'b1;

    // ordering modes
    localparam logic [MODE_W-1:0] MODE_LO_FIFO = 2'd0;
    localparam logic [MODE_W-1:0] MODE_HI_FIFO = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LO_LIFO = 2'd2;
    localparam logic [MODE_W-1:0] MODE_HI_LIFO = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    // one stored queue entry
    typedef struct packed {
        logic [TAG_W-1:0]         tag;
        logic signed [PRIO_W-1:0] prio;
    } entry_t;

    // one finished result, sequencer to output stage
    typedef struct packed {
        logic [TAG_W-1:0]         tag;
        logic signed [PRIO_W-1:0] prio;
        logic [STATUS_W-1:0]      status;
        logic                     now_empty;
    } result_t;

    // true when the incoming entry is served ahead of the stored one
    function automatic logic goes_before(
        input logic [MODE_W-1:0]      mode,
        input logic signed [PRIO_W-1:0] incoming,
        input logic signed [PRIO_W-1:0] stored
    );
        logic r;
        case (mode)
            MODE_LO_FIFO: r = incoming < stored;
            MODE_HI_FIFO: r = incoming > stored;
            MODE_LO_LIFO: r = incoming <= stored;
            MODE_HI_LIFO: r = incoming >= stored;
            default:      r = incoming >= stored;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== sv/spq_mem.sv =====
`default_nettype none
module spq_mem #(
    parameter int DEPTH = spq_pkg::QUEUE_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output spq_pkg::entry_t       rd_data,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire spq_pkg::entry_t  wr_data
);

    spq_pkg::entry_t entry_mem [DEPTH];
    spq_pkg::entry_t rd_data_reg;

    // one write port, one read port with registered data
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= entry_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// ===== sv/spq_ctrl.sv =====
`default_nettype none
`include "assert_macros.svh"
module spq_ctrl #(
    parameter int DEPTH = spq_pkg::QUEUE_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // request side
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          command,
    input  wire logic [spq_pkg::TAG_W-1:0]     element_tag,
    input  wire logic signed [spq_pkg::PRIO_W-1:0] priority_req,
    input  wire logic [spq_pkg::MODE_W-1:0]    mode,
    // result side
    output logic                               res_valid,
    input  wire logic                          res_take,
    output spq_pkg::result_t                   res,
    // memory port
    output logic                               rd_en,
    output logic [AW-1:0]                      rd_addr,
    input  wire spq_pkg::entry_t               rd_data,
    output logic                               wr_en,
    output logic [AW-1:0]                      wr_addr,
    output spq_pkg::entry_t                    wr_data
);

    localparam int SW = AW + 1;

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_EXTRACT = 6'b000010,
        S_SCAN    = 6'b000100,
        S_SHIFT   = 6'b001000,
        S_PLACE   = 6'b010000,
        S_RESULT  = 6'b100000
    } state_t;

    state_t                         state_reg, state_next;
    logic [CW-1:0]                  count_reg, count_next;
    logic [AW-1:0]                  head_reg, head_next;
    logic [CW-1:0]                  idx_reg, idx_next;
    logic [CW-1:0]                  pos_reg, pos_next;
    logic [spq_pkg::TAG_W-1:0]      tag_reg, tag_next;
    logic signed [spq_pkg::PRIO_W-1:0] prio_reg, prio_next;
    logic [spq_pkg::TAG_W-1:0]      res_tag_reg, res_tag_next;
    logic signed [spq_pkg::PRIO_W-1:0] res_prio_reg, res_prio_next;
    logic [spq_pkg::STATUS_W-1:0]   status_reg, status_next;
    logic [CW-1:0]                  idx_inc;
    logic [CW-1:0]                  count_dec;
    spq_pkg::entry_t                new_entry;

    // logical position to physical slot in the circular store
    function automatic logic [AW-1:0] phys_addr(
        input logic [AW-1:0] head,
        input logic [CW-1:0] idx
    );
        logic [SW-1:0] sum;
        sum = SW'(head) + SW'(idx);
        if (sum >= SW'(DEPTH))
        begin
            sum = sum - SW'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    assign idx_inc   = idx_reg + CW'(1);
    assign count_dec = count_reg - CW'(1);
    assign new_entry = '{tag: tag_reg, prio: prio_reg};

    // sequencer: one memory access pair per cycle, one request at a time
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        head_next     = head_reg;
        idx_next      = idx_reg;
        pos_next      = pos_reg;
        tag_next      = tag_reg;
        prio_next     = prio_reg;
        res_tag_next  = res_tag_reg;
        res_prio_next = res_prio_reg;
        status_next   = status_reg;
        rd_en         = 1'b0;
        rd_addr       = head_reg;
        wr_en         = 1'b0;
        wr_addr       = head_reg;
        wr_data       = new_entry;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    tag_next      = element_tag;
                    prio_next     = priority_req;
                    res_tag_next  = '0;
                    res_prio_next = '0;
                    status_next   = spq_pkg::STATUS_DONE;
                    idx_next      = '0;
                    if (command == spq_pkg::CMD_EXTRACT)
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = spq_pkg::STATUS_EMPTY;
                            state_next  = S_RESULT;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            state_next = S_EXTRACT;
                        end
                    end
                    else if (count_reg == CW'(DEPTH))
                    begin
                        status_next = spq_pkg::STATUS_FULL;
                        state_next  = S_RESULT;
                    end
                    else if (count_reg == '0)
                    begin
                        // empty queue: the new entry becomes the head
                        wr_en      = 1'b1;
                        wr_data    = '{tag: element_tag, prio: priority_req};
                        count_next = count_reg + CW'(1);
                        state_next = S_RESULT;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        state_next = S_SCAN;
                    end
                end
            end
            S_EXTRACT:
            begin
                // head entry is on the read port; advance the head
                res_tag_next  = rd_data.tag;
                res_prio_next = rd_data.prio;
                head_next     = phys_addr(head_reg, CW'(1));
                count_next    = count_dec;
                state_next    = S_RESULT;
            end
            S_SCAN:
            begin
                if (spq_pkg::goes_before(mode, prio_reg, rd_data.prio))
                begin
                    // insert point found, start moving the tail up from the end
                    pos_next   = idx_reg;
                    idx_next   = count_dec;
                    rd_en      = 1'b1;
                    rd_addr    = phys_addr(head_reg, count_dec);
                    state_next = S_SHIFT;
                end
                else if (idx_inc == count_reg)
                begin
                    // nothing ahead of it, append at the tail
                    wr_en      = 1'b1;
                    wr_addr    = phys_addr(head_reg, count_reg);
                    count_next = count_reg + CW'(1);
                    state_next = S_RESULT;
                end
                else
                begin
                    idx_next = idx_inc;
                    rd_en    = 1'b1;
                    rd_addr  = phys_addr(head_reg, idx_inc);
                end
            end
            S_SHIFT:
            begin
                // write entry idx one slot up while reading the one below it
                wr_en   = 1'b1;
                wr_addr = phys_addr(head_reg, idx_inc);
                wr_data = rd_data;
                if (idx_reg == pos_reg)
                begin
                    state_next = S_PLACE;
                end
                else
                begin
                    idx_next = idx_reg - CW'(1);
                    rd_en    = 1'b1;
                    rd_addr  = phys_addr(head_reg, idx_reg - CW'(1));
                end
            end
            S_PLACE:
            begin
                wr_en      = 1'b1;
                wr_addr    = phys_addr(head_reg, pos_reg);
                count_next = count_reg + CW'(1);
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            head_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            head_reg  <= head_next;
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        pos_reg      <= pos_next;
        tag_reg      <= tag_next;
        prio_reg     <= prio_next;
        res_tag_reg  <= res_tag_next;
        res_prio_reg <= res_prio_next;
        status_reg   <= status_next;
    end

    // handshake and result
    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_RESULT);
    assign res       = '{tag: res_tag_reg, prio: res_prio_reg, status: status_reg,
                         now_empty: (count_reg == '0)};

    // checks
    `SPQ_ASSERT(a_count_bound, count_reg <= CW'(DEPTH), "entry count above queue depth")
    `SPQ_ASSERT(a_shift_range, (state_reg == S_SHIFT) |-> (idx_reg >= pos_reg && idx_reg < count_reg),
                "shift index outside the moved range")
    `SPQ_ASSERT(a_extract_nonempty, (state_reg == S_EXTRACT) |-> (count_reg != '0),
                "extract started on an empty queue")
    `SPQ_ASSERT_NEXT(a_place_grows, state_reg == S_PLACE,
                     count_reg == $past(count_reg) + CW'(1), "insert did not grow the queue")

endmodule
`default_nettype wire

// ===== sv/sorted_priority_queue_top.sv =====
// Sorted priority queue of up to QUEUE_DEPTH entries (tag plus signed priority), held in one
// circular single-port-read/single-port-write memory in service order. An extract passes
// through accept, memory read and result hand-off. An insert scans from the head one entry
// per cycle until the mode comparison picks its place, then moves the entries behind that
// place up by one slot per cycle and writes the new entry; an insert that lands at the tail
// or into an empty queue needs no move. The one memory read and one memory write per cycle
// set this pace. Inserts into a full queue and extracts from an empty one go straight from
// accept to result hand-off. Output stalls hold the result hand-off. A new request is taken
// while the previous result still waits in the output register.
// order_mode is written through cfg_we/cfg_wdata; the user must do so only while the block
// is idle, which the block itself does not enforce. Stored entries are not re-sorted when
// it changes.
`default_nettype none
module sorted_priority_queue_top #(
    parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic                              command,
    input  wire logic [spq_pkg::TAG_W-1:0]         element_tag,
    input  wire logic signed [spq_pkg::PRIO_W-1:0] priority_req,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [spq_pkg::TAG_W-1:0]              out_tag,
    output logic signed [spq_pkg::PRIO_W-1:0]      out_priority,
    output logic [spq_pkg::STATUS_W-1:0]           status,
    output logic                                   now_empty,
    input  wire logic                              cfg_we,
    input  wire logic [spq_pkg::MODE_W-1:0]        cfg_wdata
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [spq_pkg::MODE_W-1:0] mode_reg;
    logic                       out_valid_reg, out_valid_next;
    spq_pkg::result_t           out_reg;
    spq_pkg::result_t           res;
    logic                       res_valid;
    logic                       out_free;
    logic                       rd_en;
    logic [AW-1:0]              rd_addr;
    spq_pkg::entry_t            rd_data;
    logic                       wr_en;
    logic [AW-1:0]              wr_addr;
    spq_pkg::entry_t            wr_data;

    spq_mem #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    spq_ctrl #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .element_tag  (element_tag),
        .priority_req (priority_req),
        .mode         (mode_reg),
        .res_valid    (res_valid),
        .res_take     (out_free),
        .res          (res),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data)
    );

    // ordering mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= spq_pkg::MODE_LO_FIFO;
        end
        else if (cfg_we)
        begin
            mode_reg <= cfg_wdata;
        end
    end

    // output register
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && out_free)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && out_free)
        begin
            out_reg <= res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_tag      = out_reg.tag;
    assign out_priority = out_reg.prio;
    assign status       = out_reg.status;
    assign now_empty    = out_reg.now_empty;

endmodule
`default_nettype wire

// ===== verif/sorted_priority_queue_top_test.sv =====
`timescale 1ns / 1ps

// tracks the queue contents and the results still owed by the block
class priority_order_checker;
    spq_pkg::entry_t  queued_entries[$];
    spq_pkg::result_t due_results[$];
    logic [spq_pkg::MODE_W-1:0] order_mode;
    int failures;

    function new();
        order_mode = spq_pkg::MODE_LO_FIFO;
        failures = 0;
    endfunction

    function void set_mode(logic [spq_pkg::MODE_W-1:0] mode);
        order_mode = mode;
    endfunction

    function int pending();
        return due_results.size();
    endfunction

    // true when the incoming priority is served ahead of a held one
    function bit serves_ahead(logic signed [spq_pkg::PRIO_W-1:0] incoming,
                              logic signed [spq_pkg::PRIO_W-1:0] held);
        bit ahead;
        case (order_mode)
            spq_pkg::MODE_LO_FIFO: ahead = incoming < held;
            spq_pkg::MODE_HI_FIFO: ahead = incoming > held;
            spq_pkg::MODE_LO_LIFO: ahead = incoming <= held;
            default:               ahead = incoming >= held;
        endcase
        return ahead;
    endfunction

    // apply one accepted request and queue the result it owes
    function void note_request(logic cmd, logic [spq_pkg::TAG_W-1:0] tag,
                               logic signed [spq_pkg::PRIO_W-1:0] prio);
        spq_pkg::result_t owed;
        spq_pkg::entry_t  item;
        int      slot;
        bit      placed;
        owed = '0;
        owed.status = spq_pkg::STATUS_DONE;
        if (cmd == spq_pkg::CMD_INSERT)
        begin
            if (queued_entries.size() >= spq_pkg::QUEUE_DEPTH_DEF)
            begin
                owed.status = spq_pkg::STATUS_FULL;
            end
            else
            begin
                slot = queued_entries.size();
                placed = 1'b0;
                for (int i = 0; i < queued_entries.size(); i++)
                begin
                    if (!placed && serves_ahead(prio, queued_entries[i].prio))
                    begin
                        slot = i;
                        placed = 1'b1;
                    end
                end
                item.tag = tag;
                item.prio = prio;
                queued_entries.insert(slot, item);
            end
        end
        else
        begin
            if (queued_entries.size() == 0)
            begin
                owed.status = spq_pkg::STATUS_EMPTY;
            end
            else
            begin
                item = queued_entries.pop_front();
                owed.tag = item.tag;
                owed.prio = item.prio;
            end
        end
        owed.now_empty = (queued_entries.size() == 0);
        due_results.push_back(owed);
    endfunction

    // compare one accepted result with the oldest one owed
    function void check_result(logic [spq_pkg::TAG_W-1:0] tag,
                               logic signed [spq_pkg::PRIO_W-1:0] prio,
                               logic [spq_pkg::STATUS_W-1:0] stat, logic empty_flag);
        spq_pkg::result_t want;
        if (due_results.size() == 0)
        begin
            failures++;
            if (failures <= 10)
                $display("%0t: result with none pending: tag=%h prio=%0d status=%0d empty=%b",
                         $time, tag, prio, stat, empty_flag);
            return;
        end
        want = due_results.pop_front();
        if (want.tag !== tag || want.prio !== prio || want.status !== stat
            || want.now_empty !== empty_flag)
        begin
            failures++;
            if (failures <= 10)
            begin
                $display("%0t: mismatch expected tag=%h prio=%0d status=%0d empty=%b",
                         $time, want.tag, want.prio, want.status, want.now_empty);
                $display("%0t:          actual   tag=%h prio=%0d status=%0d empty=%b",
                         $time, tag, prio, stat, empty_flag);
            end
        end
    endfunction
endclass

module sorted_priority_queue_top_test;

    localparam logic signed [spq_pkg::PRIO_W-1:0] PRIO_MIN = 32'sh8000_0000;
    localparam logic signed [spq_pkg::PRIO_W-1:0] PRIO_MAX = 32'sh7FFF_FFFF;
    localparam int TIMEOUT_NS = 6_000_000;
    localparam int PHASE_ITEMS = 180;

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic command;
    logic [spq_pkg::TAG_W-1:0] element_tag;
    logic signed [spq_pkg::PRIO_W-1:0] priority_req;
    logic out_valid;
    logic out_ready;
    logic [spq_pkg::TAG_W-1:0] out_tag;
    logic signed [spq_pkg::PRIO_W-1:0] out_priority;
    logic [spq_pkg::STATUS_W-1:0] status;
    logic now_empty;
    logic cfg_we;
    logic [spq_pkg::MODE_W-1:0] cfg_wdata;

    priority_order_checker sb;
    int burst_left;

    sorted_priority_queue_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .element_tag  (element_tag),
        .priority_req (priority_req),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_tag      (out_tag),
        .out_priority (out_priority),
        .status       (status),
        .now_empty    (now_empty),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata)
    );

    always #5 clk = ~clk;

    // sender pacing: bursts of random length with random gaps
    task automatic pace_sender();
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(0, 12);
        end
    endtask

    // present one request and hold it until accepted
    task automatic send_request(input logic cmd, input logic [spq_pkg::TAG_W-1:0] tag,
                                input logic signed [spq_pkg::PRIO_W-1:0] prio);
        in_valid <= 1'b1;
        command <= cmd;
        element_tag <= tag;
        priority_req <= prio;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_request(cmd, tag, prio);
        pace_sender();
    endtask

    // hold off requests until every owed result has been taken
    task automatic drain_results();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
    endtask

    task automatic write_mode(input logic [spq_pkg::MODE_W-1:0] mode);
        cfg_we <= 1'b1;
        cfg_wdata <= mode;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_mode(mode);
    endtask

    // priorities: many near zero for ties, some extremes, the rest anywhere
    function automatic logic signed [spq_pkg::PRIO_W-1:0] pick_priority();
        logic signed [spq_pkg::PRIO_W-1:0] prio;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: prio = int'($urandom_range(0, 6)) - 3;
            4:          prio = $urandom_range(0, 1) ? PRIO_MIN : PRIO_MAX;
            5:          prio = $urandom_range(0, 1) ? PRIO_MIN + 1 : PRIO_MAX - 1;
            default:    prio = $urandom;
        endcase
        return prio;
    endfunction

    function automatic logic [spq_pkg::TAG_W-1:0] pick_tag();
        logic [spq_pkg::TAG_W-1:0] tag;
        case ($urandom_range(0, 15))
            0:       tag = '0;
            1:       tag = '1;
            default: tag = $urandom;
        endcase
        return tag;
    endfunction

    // one mode setting, fill level swept by a drifting insert share
    task automatic run_phase(input logic [spq_pkg::MODE_W-1:0] mode);
        int insert_pct;
        logic cmd;
        insert_pct = 50;
        drain_results();
        write_mode(mode);
        for (int i = 0; i < PHASE_ITEMS; i++)
        begin
            if (i % 24 == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       insert_pct = 10;
                    1:       insert_pct = 45;
                    2:       insert_pct = 80;
                    default: insert_pct = 97;
                endcase
            end
            cmd = ($urandom_range(0, 99) < insert_pct) ? spq_pkg::CMD_INSERT
                                                        : spq_pkg::CMD_EXTRACT;
            send_request(cmd, pick_tag(), pick_priority());
        end
    endtask

    // receiver stalls on a rotating ready mask of varying density
    initial
    begin
        logic [15:0] ready_mask;
        int span;
        int density;
        out_ready = 1'b0;
        ready_mask = '1;
        span = 0;
        density = 100;
        forever
        begin
            @(posedge clk);
            if (span == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       density = 100;
                    1:       density = 85;
                    2:       density = 50;
                    default: density = 25;
                endcase
                for (int b = 0; b < 16; b++)
                    ready_mask[b] = ($urandom_range(0, 99) < density);
                span = $urandom_range(16, 80);
            end
            out_ready <= ready_mask[0];
            ready_mask = {ready_mask[0], ready_mask[15:1]};
            span--;
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_tag, out_priority, status, now_empty);
    end

    // run limit
    initial
    begin
        #TIMEOUT_NS;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        command = spq_pkg::CMD_INSERT;
        element_tag = '0;
        priority_req = '0;
        cfg_we = 1'b0;
        cfg_wdata = spq_pkg::MODE_LO_FIFO;
        burst_left = 0;
        sb = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        write_mode(spq_pkg::MODE_LO_FIFO);

        // extract from an empty queue
        send_request(spq_pkg::CMD_EXTRACT, 32'hFFFF_FFFF, PRIO_MAX);

        // fill to capacity with extremes and ties
        send_request(spq_pkg::CMD_INSERT, 32'h0000_0000, 0);
        send_request(spq_pkg::CMD_INSERT, 32'hFFFF_FFFF, PRIO_MAX);
        send_request(spq_pkg::CMD_INSERT, 32'h0000_0001, PRIO_MIN);
        send_request(spq_pkg::CMD_INSERT, 32'h0000_0002, -1);
        send_request(spq_pkg::CMD_INSERT, 32'h0000_0003, 0);
        send_request(spq_pkg::CMD_INSERT, 32'h0000_0004, 0);
        send_request(spq_pkg::CMD_INSERT, 32'h0000_0005, PRIO_MAX);
        send_request(spq_pkg::CMD_INSERT, 32'h0000_0006, PRIO_MIN);
        send_request(spq_pkg::CMD_INSERT, 32'h0000_0007, 1);
        for (int i = 1; i <= 7; i++)
            send_request(spq_pkg::CMD_INSERT, 32'hA5A5_0000 + i, (i % 2) ? -i : i);

        // insert into a full queue is refused
        send_request(spq_pkg::CMD_INSERT, 32'h5A5A_5A5A, PRIO_MIN);

        // mode change with entries held, no re-sort, lifo ties
        drain_results();
        write_mode(spq_pkg::MODE_HI_LIFO);
        send_request(spq_pkg::CMD_EXTRACT, 32'h1234_5678, 0);
        send_request(spq_pkg::CMD_EXTRACT, 32'h8765_4321, 0);
        send_request(spq_pkg::CMD_INSERT, 32'h0000_C0DE, 0);
        send_request(spq_pkg::CMD_INSERT, 32'h0000_C0DF, 0);
        send_request(spq_pkg::CMD_EXTRACT, 32'h0, 0);
        send_request(spq_pkg::CMD_EXTRACT, 32'h0, 0);

        // random phases over all modes
        run_phase(spq_pkg::MODE_HI_FIFO);
        run_phase(spq_pkg::MODE_LO_LIFO);
        run_phase(spq_pkg::MODE_HI_LIFO);
        run_phase(spq_pkg::MODE_LO_FIFO);
        run_phase(spq_pkg::MODE_LO_LIFO);
        run_phase(spq_pkg::MODE_HI_FIFO);
        run_phase(spq_pkg::MODE_LO_FIFO);
        run_phase(spq_pkg::MODE_HI_LIFO);

        drain_results();
        repeat (40) @(posedge clk);
        if (sb.pending() != 0)
            $display("%0d results never arrived", sb.pending());
        if (sb.failures == 0 && sb.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
